### rtl/lamg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lamg_pkg
// Shared sizes, codes, types and field conversion helpers for the labeled
// adjacency matrix graph store.
// ----------------------------------------------------------------------------
package lamg_pkg;

   // Store geometry.
   localparam int VERTEX_SLOTS = 8;
   localparam int LABEL_BITS   = 16;
   localparam int SLOT_BITS    = (VERTEX_SLOTS > 1) ? $clog2(VERTEX_SLOTS) : 1;
   localparam int CNT_BITS     = $clog2(VERTEX_SLOTS + 1);

   // Fixed widths of the transaction fields.
   localparam int MODE_W        = 3;
   localparam int LABEL_FIELD_W = 16;
   localparam int STATUS_W      = 2;
   localparam int INDEX_FIELD_W = 3;
   localparam int ROW_FIELD_W   = 8;

   typedef logic [LABEL_BITS-1:0]    label_type;
   typedef logic [VERTEX_SLOTS-1:0]  row_type;
   typedef logic [SLOT_BITS-1:0]     slot_type;
   typedef logic [CNT_BITS-1:0]      cnt_type;
   typedef logic [MODE_W-1:0]        mode_type;
   typedef logic [STATUS_W-1:0]      status_type;

   // Operation codes.
   localparam mode_type MODE_ADD_VERTEX    = 3'd0;
   localparam mode_type MODE_ADD_EDGE      = 3'd1;
   localparam mode_type MODE_REMOVE_VERTEX = 3'd2;
   localparam mode_type MODE_REMOVE_EDGE   = 3'd3;
   localparam mode_type MODE_DUMP          = 3'd4;

   // Result status codes.
   localparam status_type STATUS_OK         = 2'd0;
   localparam status_type STATUS_FULL       = 2'd1;
   localparam status_type STATUS_NOT_FOUND  = 2'd2;
   localparam status_type STATUS_ZERO_LABEL = 2'd3;

   localparam slot_type SLOT_LAST = slot_type'(VERTEX_SLOTS - 1);

   // Request from the sequencer to the store.
   typedef struct packed {
      logic      rd_en;
      slot_type  rd_addr;
      logic      wr_en;
      slot_type  wr_addr;
      label_type wr_label;
      row_type   wr_row;
   } mem_req_type;

   // Registered read data from the store.
   typedef struct packed {
      label_type label;
      row_type   row;
   } mem_rsp_type;

   // One result transaction handed to the output register.
   typedef struct packed {
      logic                     valid;
      status_type               status;
      logic [INDEX_FIELD_W-1:0] slot_index;
      logic [LABEL_FIELD_W-1:0] slot_label;
      logic [ROW_FIELD_W-1:0]   row_bits;
      logic                     last;
   } result_type;

   // Takes the low LABEL_BITS bits of a label field.
   function automatic label_type field_to_label(input logic [LABEL_FIELD_W-1:0] f);
      label_type r;
      r = '0;
      for (int i = 0; i < LABEL_BITS; i++) begin
         if (i < LABEL_FIELD_W) begin
            r[i] = f[i];
         end
      end
      return r;
   endfunction

   // Widens or narrows a stored label to the output field.
   function automatic logic [LABEL_FIELD_W-1:0] label_to_field(input label_type l);
      logic [LABEL_FIELD_W-1:0] r;
      r = '0;
      for (int i = 0; i < LABEL_FIELD_W; i++) begin
         if (i < LABEL_BITS) begin
            r[i] = l[i];
         end
      end
      return r;
   endfunction

   // Keeps the low bits of an adjacency row for the output field.
   function automatic logic [ROW_FIELD_W-1:0] row_to_field(input row_type w);
      logic [ROW_FIELD_W-1:0] r;
      r = '0;
      for (int i = 0; i < ROW_FIELD_W; i++) begin
         if (i < VERTEX_SLOTS) begin
            r[i] = w[i];
         end
      end
      return r;
   endfunction

   // Keeps the low bits of a slot number for the output field.
   function automatic logic [INDEX_FIELD_W-1:0] slot_to_field(input slot_type s);
      logic [INDEX_FIELD_W-1:0] r;
      r = '0;
      for (int i = 0; i < INDEX_FIELD_W; i++) begin
         if (i < SLOT_BITS) begin
            r[i] = s[i];
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### rtl/labeled_adjacency_matrix_graph_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// labeled_adjacency_matrix_graph_top
// Small directed graph store with labeled vertex slots and an adjacency
// bit matrix, driven by a request stream and answering on a response stream.
// ----------------------------------------------------------------------------
// Usage:
//   A request transaction on req_* carries a mode and up to two labels. Add
//   vertex, add edge, remove vertex and remove edge each give one response
//   transaction; dump gives one response per slot in slot order, with tlast
//   on the final one. Unused modes are accepted and give no response.
//   Labels and rows live in two small memories with a registered read.
//   Each add, remove or dump request, unless rejected for a zero label,
//   first walks all slots through the read port, one per cycle unless a
//   dump is stalled. Add vertex and the edge operations then pass a decide
//   state, a write state on success, and an emit state for the result.
//   Remove vertex, when the label is found, adds a second read-modify-write
//   walk over all slots to clear the freed rows and columns.
//   A dump delivers one slot per cycle while the output register has room.
//   Requests with a zero label skip the walk and go to the emit state.
//   The response sits in an output register, so a new request is accepted
//   while a finished response waits. When rsp_tready is low the block holds
//   its response and, for a dump, pauses its walk until room frees up.
//   A synchronous reset empties every slot and removes every edge at once.
// ----------------------------------------------------------------------------
module labeled_adjacency_matrix_graph_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // Fields from bit 0: mode[2:0], first_label[18:3], second_label[34:19].
   input  wire logic [39:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // Fields from bit 0: status[1:0], slot_index[4:2], slot_label[20:5],
   // row_bits[28:21].
   output logic [31:0]      rsp_tdata,
   output logic             rsp_tlast
);

   logic                  req_accept;
   logic                  seq_ready;
   logic                  can_load;
   lamg_pkg::result_type  res;
   lamg_pkg::mem_req_type mem_req;
   lamg_pkg::mem_rsp_type mem_rsp;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [31:0]           rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;

   assign req_tready = seq_ready;
   assign req_accept = req_tvalid && seq_ready;
   assign can_load   = !rsp_valid_ff || rsp_tready;

   lamg_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (req_accept),
      .start_mode (req_tdata[2:0]),
      .start_a    (lamg_pkg::field_to_label(req_tdata[18:3])),
      .start_b    (lamg_pkg::field_to_label(req_tdata[34:19])),
      .ready      (seq_ready),
      .can_load   (can_load),
      .res        (res),
      .mem_req    (mem_req),
      .mem_rsp    (mem_rsp)
   );

   lamg_store u_store (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .mem_rsp (mem_rsp)
   );

   // Output register: loads a result when empty or being drained.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (res.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {3'b000, res.row_bits, res.slot_label, res.slot_index, res.status};
         rsp_last_in  = res.last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

### rtl/lamg_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lamg_store
// Label and adjacency row memories with one write port, one read port and a
// registered read. Per-slot valid bits make unwritten slots read as free.
// ----------------------------------------------------------------------------
module lamg_store (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire lamg_pkg::mem_req_type mem_req,
   output lamg_pkg::mem_rsp_type      mem_rsp
);

   lamg_pkg::label_type label_mem_ff [lamg_pkg::VERTEX_SLOTS];
   lamg_pkg::row_type   row_mem_ff   [lamg_pkg::VERTEX_SLOTS];

   logic [lamg_pkg::VERTEX_SLOTS-1:0] valid_ff;
   logic                              q_valid_ff;
   lamg_pkg::label_type               q_label_ff;
   lamg_pkg::row_type                 q_row_ff;

   // Memory write and registered read.
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         label_mem_ff[mem_req.wr_addr] <= mem_req.wr_label;
         row_mem_ff[mem_req.wr_addr]   <= mem_req.wr_row;
      end
      if (mem_req.rd_en) begin
         q_label_ff <= label_mem_ff[mem_req.rd_addr];
         q_row_ff   <= row_mem_ff[mem_req.rd_addr];
      end
   end

   // Valid bits: a slot becomes valid on its first write.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         q_valid_ff <= 1'b0;
      end else begin
         if (mem_req.wr_en) begin
            valid_ff[mem_req.wr_addr] <= 1'b1;
         end
         if (mem_req.rd_en) begin
            q_valid_ff <= valid_ff[mem_req.rd_addr];
         end
      end
   end

   // A slot never written reads as free with no edges.
   assign mem_rsp.label = q_valid_ff ? q_label_ff : '0;
   assign mem_rsp.row   = q_valid_ff ? q_row_ff : '0;

endmodule
`default_nettype wire

### rtl/lamg_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lamg_seq
// Operation sequencer: scans the store one slot per cycle unless stalled,
// decides the operation, writes back, hands results to the output register.
// ----------------------------------------------------------------------------
module lamg_seq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire lamg_pkg::mode_type    start_mode,
   input  wire lamg_pkg::label_type   start_a,
   input  wire lamg_pkg::label_type   start_b,
   output logic                       ready,
   input  wire logic                  can_load,
   output lamg_pkg::result_type       res,
   output lamg_pkg::mem_req_type      mem_req,
   input  wire lamg_pkg::mem_rsp_type mem_rsp
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_WRITE  = 3'd3;
   localparam logic [2:0] S_SWEEP  = 3'd4;
   localparam logic [2:0] S_EMIT   = 3'd5;

   logic [2:0]            state_ff, state_in;
   lamg_pkg::mode_type    mode_ff, mode_in;
   lamg_pkg::label_type   a_ff, a_in;
   lamg_pkg::label_type   b_ff, b_in;
   lamg_pkg::cnt_type     issue_cnt_ff, issue_cnt_in;
   logic                  rd_pending_ff, rd_pending_in;
   lamg_pkg::slot_type    rd_idx_ff, rd_idx_in;
   logic                  free_found_ff, free_found_in;
   lamg_pkg::slot_type    free_idx_ff, free_idx_in;
   logic                  src_found_ff, src_found_in;
   lamg_pkg::slot_type    src_idx_ff, src_idx_in;
   logic                  dst_found_ff, dst_found_in;
   lamg_pkg::slot_type    dst_idx_ff, dst_idx_in;
   lamg_pkg::row_type     dst_row_ff, dst_row_in;
   lamg_pkg::row_type     match_mask_ff, match_mask_in;
   lamg_pkg::status_type  res_status_ff, res_status_in;
   lamg_pkg::slot_type    res_idx_ff, res_idx_in;
   lamg_pkg::label_type   res_label_ff, res_label_in;
   lamg_pkg::row_type     res_row_ff, res_row_in;

   logic              walking;
   logic              stall;
   logic              issue;
   logic              consume;
   logic              last_consume;
   logic              is_edge;
   lamg_pkg::row_type src_bit;

   assign ready   = (state_ff == S_IDLE);
   assign walking = (state_ff == S_SCAN) || (state_ff == S_SWEEP);
   // A dump result waits in the read register while the output is full.
   assign stall   = (state_ff == S_SCAN) && (mode_ff == lamg_pkg::MODE_DUMP) &&
                    rd_pending_ff && !can_load;
   assign issue   = walking && !stall &&
                    (issue_cnt_ff < lamg_pkg::cnt_type'(lamg_pkg::VERTEX_SLOTS));
   assign consume = walking && rd_pending_ff && !stall;
   assign last_consume = consume && (rd_idx_ff == lamg_pkg::SLOT_LAST);
   assign is_edge = (start_mode == lamg_pkg::MODE_ADD_EDGE) ||
                    (start_mode == lamg_pkg::MODE_REMOVE_EDGE);
   assign src_bit = lamg_pkg::row_type'(1) << src_idx_ff;

   // Next-state logic for the sequencer and its scan trackers.
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      issue_cnt_in  = issue_cnt_ff;
      rd_pending_in = rd_pending_ff;
      rd_idx_in     = rd_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      src_found_in  = src_found_ff;
      src_idx_in    = src_idx_ff;
      dst_found_in  = dst_found_ff;
      dst_idx_in    = dst_idx_ff;
      dst_row_in    = dst_row_ff;
      match_mask_in = match_mask_ff;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      res_label_in  = res_label_ff;
      res_row_in    = res_row_ff;

      mem_req          = '0;
      mem_req.rd_en    = issue;
      mem_req.rd_addr  = issue_cnt_ff[lamg_pkg::SLOT_BITS-1:0];

      res = '0;

      // Read pipeline shared by the scan and the sweep.
      if (issue) begin
         issue_cnt_in  = issue_cnt_ff + lamg_pkg::cnt_type'(1);
         rd_pending_in = 1'b1;
         rd_idx_in     = issue_cnt_ff[lamg_pkg::SLOT_BITS-1:0];
      end else if (consume) begin
         rd_pending_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in       = start_mode;
               a_in          = start_a;
               b_in          = start_b;
               issue_cnt_in  = '0;
               rd_pending_in = 1'b0;
               free_found_in = 1'b0;
               src_found_in  = 1'b0;
               dst_found_in  = 1'b0;
               match_mask_in = '0;
               res_status_in = lamg_pkg::STATUS_ZERO_LABEL;
               res_idx_in    = '0;
               res_label_in  = '0;
               res_row_in    = '0;
               if (start_mode == lamg_pkg::MODE_DUMP) begin
                  state_in = S_SCAN;
               end else if (start_mode > lamg_pkg::MODE_DUMP) begin
                  state_in = S_IDLE;
               end else if (start_a == '0 || (is_edge && start_b == '0)) begin
                  state_in = S_EMIT;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            if (consume) begin
               // Lowest free slot, highest slot per label, and the match set.
               if (mem_rsp.label == '0 && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = rd_idx_ff;
               end
               if (mem_rsp.label == a_ff) begin
                  src_found_in             = 1'b1;
                  src_idx_in               = rd_idx_ff;
                  match_mask_in[rd_idx_ff] = 1'b1;
               end
               if (mem_rsp.label == b_ff) begin
                  dst_found_in = 1'b1;
                  dst_idx_in   = rd_idx_ff;
                  dst_row_in   = mem_rsp.row;
               end
               if (mode_ff == lamg_pkg::MODE_DUMP) begin
                  res.valid      = 1'b1;
                  res.status     = lamg_pkg::STATUS_OK;
                  res.slot_index = lamg_pkg::slot_to_field(rd_idx_ff);
                  res.slot_label = lamg_pkg::label_to_field(mem_rsp.label);
                  res.row_bits   = lamg_pkg::row_to_field(mem_rsp.row);
                  res.last       = (rd_idx_ff == lamg_pkg::SLOT_LAST);
               end
            end
            if (last_consume) begin
               state_in = (mode_ff == lamg_pkg::MODE_DUMP) ? S_IDLE : S_DECIDE;
            end
         end

         S_DECIDE: begin
            res_status_in = lamg_pkg::STATUS_NOT_FOUND;
            res_idx_in    = '0;
            res_label_in  = '0;
            res_row_in    = '0;
            state_in      = S_EMIT;
            unique case (mode_ff)
               lamg_pkg::MODE_ADD_VERTEX: begin
                  if (free_found_ff) begin
                     res_status_in = lamg_pkg::STATUS_OK;
                     res_idx_in    = free_idx_ff;
                     res_label_in  = a_ff;
                     state_in      = S_WRITE;
                  end else begin
                     res_status_in = lamg_pkg::STATUS_FULL;
                  end
               end
               lamg_pkg::MODE_REMOVE_VERTEX: begin
                  if (src_found_ff) begin
                     res_status_in = lamg_pkg::STATUS_OK;
                     res_idx_in    = src_idx_ff;
                     issue_cnt_in  = '0;
                     rd_pending_in = 1'b0;
                     state_in      = S_SWEEP;
                  end
               end
               default: begin
                  if (src_found_ff && dst_found_ff) begin
                     res_status_in = lamg_pkg::STATUS_OK;
                     res_idx_in    = dst_idx_ff;
                     res_label_in  = b_ff;
                     res_row_in    = (mode_ff == lamg_pkg::MODE_ADD_EDGE) ?
                                     (dst_row_ff | src_bit) : (dst_row_ff & ~src_bit);
                     state_in      = S_WRITE;
                  end
               end
            endcase
         end

         S_WRITE: begin
            mem_req.wr_en    = 1'b1;
            mem_req.wr_addr  = res_idx_ff;
            mem_req.wr_label = res_label_ff;
            mem_req.wr_row   = res_row_ff;
            state_in         = S_EMIT;
         end

         S_SWEEP: begin
            // Free every matching slot and clear their columns everywhere.
            if (consume) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = rd_idx_ff;
               if (match_mask_ff[rd_idx_ff]) begin
                  mem_req.wr_label = '0;
                  mem_req.wr_row   = '0;
               end else begin
                  mem_req.wr_label = mem_rsp.label;
                  mem_req.wr_row   = mem_rsp.row & ~match_mask_ff;
               end
            end
            if (last_consume) begin
               state_in = S_EMIT;
            end
         end

         S_EMIT: begin
            if (can_load) begin
               res.valid      = 1'b1;
               res.status     = res_status_ff;
               res.slot_index = lamg_pkg::slot_to_field(res_idx_ff);
               res.slot_label = lamg_pkg::label_to_field(res_label_ff);
               res.row_bits   = lamg_pkg::row_to_field(res_row_ff);
               res.last       = 1'b1;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rd_pending_ff <= 1'b0;
         issue_cnt_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         rd_pending_ff <= rd_pending_in;
         issue_cnt_ff  <= issue_cnt_in;
      end
   end

   // Operands, trackers and the pending result.
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      rd_idx_ff     <= rd_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      src_found_ff  <= src_found_in;
      src_idx_ff    <= src_idx_in;
      dst_found_ff  <= dst_found_in;
      dst_idx_ff    <= dst_idx_in;
      dst_row_ff    <= dst_row_in;
      match_mask_ff <= match_mask_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      res_label_ff  <= res_label_in;
      res_row_ff    <= res_row_in;
   end

`ifndef NO_ASSERTIONS
   // A result is offered only when the output register can take it.
   a_res_needs_room: assert property (@(posedge clock) disable iff (reset)
      res.valid |-> can_load)
      else $error("result offered while output register is full");

   // The sweep never writes the entry that is being read in the same cycle.
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (mem_req.wr_en && mem_req.rd_en) |-> (mem_req.wr_addr != mem_req.rd_addr))
      else $error("store read and write hit the same slot");

   // The search pass leaves the store untouched.
   a_scan_read_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> !mem_req.wr_en)
      else $error("store written during the search pass");

   // A vertex removal sweep always has at least one slot to free.
   a_sweep_has_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWEEP) |-> (match_mask_ff != '0))
      else $error("removal sweep with an empty match set");

   // New input is taken only while the sequencer is idle.
   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> ready)
      else $error("transaction started while busy");
`endif

endmodule
`default_nettype wire
